[rtl/core/ryxy_pkg.sv]
// ryxy_pkg: constants and types shared by the RGB to Yxy converter.
// No dependencies.
`timescale 1ns / 1ps
package ryxy_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int COEFF_FRAC_BITS = 16;

  localparam int TBL_AW   = $clog2(TABLE_DEPTH);
  localparam int CODE_W   = 8;
  localparam int LIN_W    = 16;
  localparam int COEFF_W  = COEFF_FRAC_BITS + 2;
  localparam int CFG_W    = 54;
  localparam int CFG_AW   = 2;
  localparam int PROD_W   = LIN_W + 1 + COEFF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ROW_W    = ACC_W - COEFF_FRAC_BITS;
  localparam int SUM_W    = ROW_W + 2;
  localparam int Q_W      = 17;
  localparam int DIV_STAGES = Q_W;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_t;

  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef logic        [LIN_W-1:0]  lin_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic        [ROW_W-1:0]  row_t;
  typedef logic        [SUM_W-1:0]  sum_t;
  typedef logic        [Q_W-1:0]    quot_t;

endpackage

[rtl/core/ryxy_if.sv]
// ryxy_if: request, result and register write channels of the converter.
// Depends on ryxy_pkg.
`timescale 1ns / 1ps
interface ryxy_in_if import ryxy_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CODE_W-1:0] red;
  logic [CODE_W-1:0] green;
  logic [CODE_W-1:0] blue;
  logic [TBL_AW-1:0] table_index;
  logic [LIN_W-1:0]  table_value;
  modport source (output valid, req_type, red, green, blue, table_index, table_value,
                  input ready);
  modport sink   (input valid, req_type, red, green, blue, table_index, table_value,
                  output ready);
endinterface

interface ryxy_out_if import ryxy_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] luminance;
  logic [15:0] chroma_x;
  logic [15:0] chroma_y;
  logic        zero_sum;
  modport source (output valid, luminance, chroma_x, chroma_y, zero_sum, input ready);
  modport sink   (input valid, luminance, chroma_x, chroma_y, zero_sum, output ready);
endinterface

interface ryxy_cfg_if import ryxy_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [CFG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/rgb_pixel_to_yxy.sv]
// rgb_pixel_to_yxy: top level, 8-bit RGB pixel to luminance Y and chromaticity x,y.
// Depends on ryxy_pkg and the channel interfaces in ryxy_if.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : requests. req_type 0 writes table_value into decoding table entry
//            table_index (no result); req_type 1 converts red/green/blue.
//   out_ch : one result per pixel request, in request order.
//   cfg_ch : writes matrix rows X, Y, Z (index 0..2), always ready; write only
//            while no pixel is in flight.
//   Load all table entries used by the pixels before sending them.
// Stages: table read, nine products, row sums and clamp, X+Y+Z, then two
//   restoring dividers of 17 stages, one quotient bit per stage.
// Throughput: one request per cycle while out_ch is not stalled.
// Stall: the whole pipeline holds while out_ch.valid is high and out_ch.ready is
//   low; in_ch.ready is low for that cycle, nothing is lost or repeated.
// Reset: rst_n synchronous; clears all valid bits and the matrix rows. The
//   decoding table is not cleared.
module rgb_pixel_to_yxy import ryxy_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ryxy_in_if.sink   in_ch,
  ryxy_out_if.source out_ch,
  ryxy_cfg_if.sink  cfg_ch
);

  logic             adv;
  logic             in_acc;
  logic [CFG_W-1:0] row_r [3];

  // table read stage
  lin_t             tbl_mem [3][TABLE_DEPTH];
  lin_t             lin_r   [3];
  logic [2:0]       lin_ok_r;
  logic             v1_r;

  // products
  prod_t            prod_r [3][3];
  logic             v2_r;

  // rows
  row_t             row_val_r [3];
  logic             v3_r;

  // sum
  sum_t             sum_r;
  row_t             bx_r, by_r;
  logic [15:0]      lum_r;
  logic             v4_r;

  // dividers
  sum_t             remx_r [DIV_STAGES];
  sum_t             remy_r [DIV_STAGES];
  quot_t            qx_r   [DIV_STAGES];
  quot_t            qy_r   [DIV_STAGES];
  sum_t             den_r  [DIV_STAGES];
  logic [15:0]      dlum_r [DIV_STAGES];
  logic             dzero_r[DIV_STAGES];
  logic             dv_r   [DIV_STAGES];

  assign adv         = !dv_r[DIV_STAGES-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) row_r[i] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ROW_X: row_r[0] <= cfg_ch.data;
        REG_ROW_Y: row_r[1] <= cfg_ch.data;
        REG_ROW_Z: row_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int j = 0; j < DIV_STAGES; j++) dv_r[j] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_acc && (in_ch.req_type == REQ_PIXEL);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r[0] <= v4_r;
      for (int j = 1; j < DIV_STAGES; j++) dv_r[j] <= dv_r[j-1];
    end
  end

  // decoding table, one copy per channel
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.req_type == REQ_TABLE &&
        32'(in_ch.table_index) < TABLE_DEPTH) begin
      for (int k = 0; k < 3; k++)
        tbl_mem[k][TBL_AW'(in_ch.table_index)] <= in_ch.table_value;
    end
    if (in_acc && in_ch.req_type == REQ_PIXEL) begin
      lin_r[0]    <= tbl_mem[0][TBL_AW'(in_ch.red)];
      lin_r[1]    <= tbl_mem[1][TBL_AW'(in_ch.green)];
      lin_r[2]    <= tbl_mem[2][TBL_AW'(in_ch.blue)];
      lin_ok_r[0] <= 32'(in_ch.red)   < TABLE_DEPTH;
      lin_ok_r[1] <= 32'(in_ch.green) < TABLE_DEPTH;
      lin_ok_r[2] <= 32'(in_ch.blue)  < TABLE_DEPTH;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r][k] <= signed'({1'b0, (lin_ok_r[k] ? lin_r[k] : lin_t'(0))}) *
                          signed'(row_r[r][k*COEFF_W +: COEFF_W]);
        end
      end
      for (int r = 0; r < 3; r++) begin
        automatic acc_t acc = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) +
                              ACC_W'(prod_r[r][2]);
        row_val_r[r] <= (acc <= 0) ? '0 : acc[ACC_W-1:COEFF_FRAC_BITS];
      end
      sum_r <= SUM_W'(row_val_r[0]) + SUM_W'(row_val_r[1]) + SUM_W'(row_val_r[2]);
      bx_r  <= row_val_r[0];
      by_r  <= row_val_r[1];
      lum_r <= (row_val_r[1] > ROW_W'(16'hFFFF)) ? 16'hFFFF : row_val_r[1][15:0];

      // first divider stage: quotient bit 16, numerator never exceeds the sum
      remx_r[0]  <= (SUM_W'(bx_r) >= sum_r) ? SUM_W'(bx_r) - sum_r : SUM_W'(bx_r);
      remy_r[0]  <= (SUM_W'(by_r) >= sum_r) ? SUM_W'(by_r) - sum_r : SUM_W'(by_r);
      qx_r[0]    <= {(SUM_W'(bx_r) >= sum_r), {(Q_W-1){1'b0}}};
      qy_r[0]    <= {(SUM_W'(by_r) >= sum_r), {(Q_W-1){1'b0}}};
      den_r[0]   <= sum_r;
      dlum_r[0]  <= lum_r;
      dzero_r[0] <= (sum_r == '0);

      for (int j = 1; j < DIV_STAGES; j++) begin
        automatic logic [SUM_W:0] sx = {remx_r[j-1], 1'b0};
        automatic logic [SUM_W:0] sy = {remy_r[j-1], 1'b0};
        automatic logic [SUM_W:0] d  = {1'b0, den_r[j-1]};
        automatic logic           bx = sx >= d;
        automatic logic           by = sy >= d;
        remx_r[j]  <= bx ? SUM_W'(sx - d) : SUM_W'(sx);
        remy_r[j]  <= by ? SUM_W'(sy - d) : SUM_W'(sy);
        qx_r[j]    <= qx_r[j-1] | (Q_W'(bx) << (Q_W-1-j));
        qy_r[j]    <= qy_r[j-1] | (Q_W'(by) << (Q_W-1-j));
        den_r[j]   <= den_r[j-1];
        dlum_r[j]  <= dlum_r[j-1];
        dzero_r[j] <= dzero_r[j-1];
      end
    end
  end

  localparam int LAST = DIV_STAGES - 1;

  assign out_ch.valid     = dv_r[LAST];
  assign out_ch.luminance = dlum_r[LAST];
  assign out_ch.zero_sum  = dzero_r[LAST];
  assign out_ch.chroma_x  = dzero_r[LAST] ? 16'h0 :
                            qx_r[LAST][Q_W-1] ? 16'hFFFF : qx_r[LAST][15:0];
  assign out_ch.chroma_y  = dzero_r[LAST] ? 16'h0 :
                            qy_r[LAST][Q_W-1] ? 16'hFFFF : qy_r[LAST][15:0];

`ifndef SYNTHESIS
  a_zero_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_sum |-> out_ch.chroma_x == '0 && out_ch.chroma_y == '0)
    else $error("zero sum with non-zero chromaticity");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[LAST] && !dzero_r[LAST] |-> remx_r[LAST] < den_r[LAST] &&
                                     remy_r[LAST] < den_r[LAST])
    else $error("divider remainder not below sum");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v3_r) && $stable(v1_r))
    else $error("pipeline moved during stall");
`endif

endmodule

[dv/ryxy_checker.sv]
// ryxy_checker: predicts Yxy results of the RGB to Yxy converter and compares them.
// Depends on ryxy_pkg and the channel interfaces in ryxy_if.
`timescale 1ns / 1ps
module ryxy_checker import ryxy_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ryxy_in_if.sink    in_ch,
  ryxy_out_if.sink   out_ch,
  ryxy_cfg_if.sink   cfg_ch,
  output int         fail_count,
  output int         pending_count
);
  typedef struct packed {
    logic [15:0] luminance;
    logic [15:0] chroma_x;
    logic [15:0] chroma_y;
    logic        zero_sum;
  } yxy_t;

  logic [LIN_W-1:0] lin_table [TABLE_DEPTH];
  logic [CFG_W-1:0] rows [3];
  yxy_t             yxy_queue [$];

  function automatic longint coeff_at(logic [CFG_W-1:0] r, int k);
    logic [COEFF_W-1:0] f;
    f = r[k*COEFF_W +: COEFF_W];
    return longint'($signed(f));
  endfunction

  function automatic longint row_value(logic [CFG_W-1:0] r, longint lr, longint lg,
                                       longint lb);
    longint acc;
    acc = lr * coeff_at(r, 0) + lg * coeff_at(r, 1) + lb * coeff_at(r, 2);
    if (acc <= 0) return 0;
    return acc >>> COEFF_FRAC_BITS;
  endfunction

  function automatic longint ratio(longint num, longint den);
    longint q;
    q = (num << 16) / den;
    return q > 65535 ? 65535 : q;
  endfunction

  function automatic yxy_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint bx, by, bz, s;
    yxy_t   e;
    bx = row_value(rows[REG_ROW_X], lin_table[r], lin_table[g], lin_table[b]);
    by = row_value(rows[REG_ROW_Y], lin_table[r], lin_table[g], lin_table[b]);
    bz = row_value(rows[REG_ROW_Z], lin_table[r], lin_table[g], lin_table[b]);
    s = bx + by + bz;
    e.luminance = by > 65535 ? 16'hFFFF : by[15:0];
    if (s == 0) begin
      e.chroma_x = '0;
      e.chroma_y = '0;
      e.zero_sum = 1'b1;
    end else begin
      e.chroma_x = 16'(ratio(bx, s));
      e.chroma_y = 16'(ratio(by, s));
      e.zero_sum = 1'b0;
    end
    return e;
  endfunction

  assign pending_count = yxy_queue.size();

  always @(posedge clk) begin
    yxy_t e, a;
    if (!rst_n) begin
      rows[0] <= '0;
      rows[1] <= '0;
      rows[2] <= '0;
      yxy_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index != REG_NONE)
        rows[cfg_ch.index] <= cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.req_type == REQ_TABLE)
          lin_table[in_ch.table_index] = in_ch.table_value;
        else
          yxy_queue.push_back(convert_pixel(in_ch.red, in_ch.green, in_ch.blue));
      end
      if (out_ch.valid && out_ch.ready) begin
        a = '{out_ch.luminance, out_ch.chroma_x, out_ch.chroma_y, out_ch.zero_sum};
        if (yxy_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, a);
          fail_count <= fail_count + 1;
        end else begin
          e = yxy_queue.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch expected Y=%h x=%h y=%h z=%b actual Y=%h x=%h y=%h z=%b",
                     $time, e.luminance, e.chroma_x, e.chroma_y, e.zero_sum,
                     a.luminance, a.chroma_x, a.chroma_y, a.zero_sum);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/tb.sv]
// tb: stimulus and verdict for the RGB to Yxy converter.
// Depends on ryxy_pkg, ryxy_if, rgb_pixel_to_yxy and ryxy_checker.
`timescale 1ns / 1ps
module tb;
  import ryxy_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, idle_cycles;
  int   pct_idle = 23;
  bit   done = 1'b0;
  bit   timed_out = 1'b0;

  ryxy_in_if  in_ch ();
  ryxy_out_if out_ch ();
  ryxy_cfg_if cfg_ch ();

  rgb_pixel_to_yxy dut (.clk, .rst_n, .in_ch, .out_ch, .cfg_ch);
  ryxy_checker chk (.clk, .rst_n, .in_ch, .out_ch, .cfg_ch, .fail_count, .pending_count);

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TABLE;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROW_X;
    cfg_ch.data = '0;
  end

  always @(posedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= pct_idle);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !done && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(logic t, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] idx, logic [15:0] v);
    while ($urandom_range(99) < pct_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= t;
    in_ch.red <= r;
    in_ch.green <= g;
    in_ch.blue <= b;
    in_ch.table_index <= idx;
    in_ch.table_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_request(REQ_PIXEL, r, g, b, 8'($urandom), 16'($urandom));
  endtask

  task automatic write_entry(logic [7:0] idx, logic [15:0] v);
    send_request(REQ_TABLE, 8'($urandom), 8'($urandom), 8'($urandom), idx, v);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  function automatic logic [CFG_W-1:0] pack_row(logic [17:0] cr, logic [17:0] cg,
                                                logic [17:0] cb);
    return {cb, cg, cr};
  endfunction

  function automatic logic [CFG_W-1:0] rand_row();
    return CFG_W'({$urandom, $urandom});
  endfunction

  task automatic set_matrix(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y,
                            logic [CFG_W-1:0] z);
    drain();
    write_reg(REG_ROW_X, x);
    write_reg(REG_ROW_Y, y);
    write_reg(REG_ROW_Z, z);
    write_reg(REG_NONE, rand_row());
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_pixels(int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) write_entry(8'($urandom), 16'($urandom));
      else pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // load a full table, extremes at both ends
    for (int i = 0; i < TABLE_DEPTH; i++)
      write_entry(8'(i), i == 0 ? 16'h0 : (i == 255 ? 16'hFFFF : 16'($urandom)));
    // reset matrix: everything zero sum
    pixel(8'd0, 8'd0, 8'd0);
    pixel(8'd255, 8'd255, 8'd255);
    // sRGB-like matrix
    set_matrix(pack_row(18'h06988, 18'h05B8E, 18'h02E23),
               pack_row(18'h0366F, 18'h0B718, 18'h0127A),
               pack_row(18'h00319, 18'h01E82, 18'h0F378));
    pixel(8'd255, 8'd255, 8'd255);
    pixel(8'd255, 8'd0, 8'd0);
    pixel(8'd0, 8'd255, 8'd0);
    pixel(8'd0, 8'd0, 8'd255);
    pixel(8'd0, 8'd0, 8'd0);
    write_entry(8'hFF, 16'hFFFF);
    pixel(8'hAA, 8'h55, 8'hFF);
    // Y only: chroma y saturates, luminance saturates
    set_matrix('0, pack_row(18'h1FFFF, 18'h1FFFF, 18'h1FFFF), '0);
    pixel(8'd255, 8'd255, 8'd255);
    pixel(8'd255, 8'd0, 8'd0);
    // most negative coefficients in X and Y, minus one in Z: all rows clamp to zero
    set_matrix({3{18'h20000}}, {3{18'h20000}}, {3{18'h3FFFF}});
    pixel(8'd255, 8'd255, 8'd255);
    pixel(8'd0, 8'd0, 8'd0);
    // all ones and mixed signs
    set_matrix({CFG_W{1'b1}}, pack_row(18'h1FFFF, 18'h20000, 18'h00001),
               pack_row(18'h00001, 18'h00000, 18'h1FFFF));
    pixel(8'd255, 8'd1, 8'd128);
    pixel(8'd1, 8'd255, 8'd0);
    // random phases: a long stretch without idling in the third one
    for (int ph = 0; ph < 6; ph++) begin
      pct_idle = (ph == 2) ? 0 : 23;
      if (ph % 2 == 0)
        set_matrix(rand_row(), rand_row(), rand_row());
      else
        set_matrix(pack_row(18'($urandom_range(20000)), 18'($urandom_range(50000)),
                            18'($urandom_range(20000))),
                   pack_row(18'($urandom_range(20000)), 18'($urandom_range(50000)),
                            18'($urandom_range(20000))),
                   pack_row(18'($urandom_range(20000)), 18'($urandom_range(50000)),
                            18'($urandom_range(20000))));
      random_pixels(230);
    end
    pct_idle = 23;
    drain();
    done = 1'b1;
    $display("Ran a full table load, directed matrix extremes and about 1400 random");
    $display("pixels and table rewrites across ten matrix settings with random stalls.");
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/ryxy_pkg.sv
rtl/core/ryxy_if.sv
rtl/core/rgb_pixel_to_yxy.sv
dv/ryxy_checker.sv
dv/tb.sv
